### hdl/blr_pkg.sv
`default_nettype none

package blr_pkg;

  // fixed field widths at the ports
  localparam int unsigned COORD_W = 6;
  localparam int unsigned COLOR_W = 32;

  // command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = 1;
  localparam int unsigned CMDQ_CNT_W = 2;

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] color;
  } line_cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } pixel_t;

  // classified line, major axis rising
  typedef struct packed {
    logic               steep;
    logic               minor_up;
    logic [COORD_W-1:0] major_start;
    logic [COORD_W-1:0] major_end;
    logic [COORD_W-1:0] minor_start;
    logic [COORD_W-1:0] dmaj;
    logic [COORD_W:0]   dmin2;
    logic [COLOR_W-1:0] color;
  } seg_t;

endpackage

`default_nettype wire

### hdl/blr_front.sv
`default_nettype none

module blr_front #(
  parameter int unsigned COORD_BITS = 6
) (
  input  blr_pkg::line_cmd_t cmd_i,
  output blr_pkg::seg_t      seg_o
);
  import blr_pkg::*;

  localparam int unsigned C = COORD_BITS;

  logic [C-1:0] ax, ay, bx, by;
  logic [C-1:0] adx, ady;
  logic         steep;
  logic [C-1:0] s0, s1, m0, m1;
  logic         swap;
  logic [C-1:0] ps, pe, ms, me;
  logic [C-1:0] dmin;

  always_comb begin
    // wrap coordinates into the tile
    ax = cmd_i.x_start[C-1:0];
    ay = cmd_i.y_start[C-1:0];
    bx = cmd_i.x_end[C-1:0];
    by = cmd_i.y_end[C-1:0];

    adx   = (ax >= bx) ? ax - bx : bx - ax;
    ady   = (ay >= by) ? ay - by : by - ay;
    steep = adx < ady;

    s0 = steep ? ay : ax;
    m0 = steep ? ax : ay;
    s1 = steep ? by : bx;
    m1 = steep ? bx : by;

    swap = s0 > s1;
    ps   = swap ? s1 : s0;
    pe   = swap ? s0 : s1;
    ms   = swap ? m1 : m0;
    me   = swap ? m0 : m1;

    dmin = (me >= ms) ? me - ms : ms - me;

    seg_o.steep       = steep;
    seg_o.minor_up    = me > ms;
    seg_o.major_start = COORD_W'(ps);
    seg_o.major_end   = COORD_W'(pe);
    seg_o.minor_start = COORD_W'(ms);
    seg_o.dmaj        = COORD_W'(pe - ps);
    seg_o.dmin2       = (COORD_W + 1)'({dmin, 1'b0});
    seg_o.color       = cmd_i.color;
  end

endmodule

`default_nettype wire

### hdl/blr_cmd_fifo.sv
`default_nettype none

module blr_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  blr_pkg::seg_t  wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output blr_pkg::seg_t  rd_data_o,
  output logic           valid_o
);
  import blr_pkg::*;

  seg_t                  mem_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_wr, do_rd;

  assign full_o    = cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH);
  assign valid_o   = cnt_q != '0;
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i & ~full_o;
  assign do_rd     = rd_en_i & valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

### hdl/blr_back.sv
`default_nettype none

module blr_back #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            seg_valid_i,
  input  blr_pkg::seg_t   seg_i,
  output logic            seg_pop_o,
  output logic            empty,
  input  logic            pop,
  output blr_pkg::pixel_t pixel_o
);
  import blr_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned EW = C + 3;

  logic                 busy_q, busy_d;
  logic                 steep_q, steep_d;
  logic                 up_q, up_d;
  logic [C-1:0]         p_q, p_d;
  logic [C-1:0]         pend_q, pend_d;
  logic [C-1:0]         minor_q, minor_d;
  logic [C-1:0]         dmaj_q, dmaj_d;
  logic [C:0]           dmin2_q, dmin2_d;
  logic signed [EW-1:0] err_q, err_d;
  logic [COLOR_W-1:0]   color_q, color_d;

  logic                 out_valid_q, out_valid_d;
  pixel_t               out_q, out_d;

  logic                 can_emit;
  logic                 is_last;
  logic signed [EW-1:0] err_sum;
  logic [C-1:0]         px, py;

  assign empty    = ~out_valid_q;
  assign pixel_o  = out_q;
  assign can_emit = ~out_valid_q | pop;
  assign is_last  = p_q == pend_q;
  assign err_sum  = err_q + $signed({2'b00, dmin2_q});
  assign px       = steep_q ? minor_q : p_q;
  assign py       = steep_q ? p_q : minor_q;

  always_comb begin
    busy_d      = busy_q;
    steep_d     = steep_q;
    up_d        = up_q;
    p_d         = p_q;
    pend_d      = pend_q;
    minor_d     = minor_q;
    dmaj_d      = dmaj_q;
    dmin2_d     = dmin2_q;
    err_d       = err_q;
    color_d     = color_q;
    out_valid_d = out_valid_q & ~pop;
    out_d       = out_q;
    seg_pop_o   = 1'b0;

    if (busy_q) begin
      if (can_emit) begin
        out_valid_d       = 1'b1;
        out_d.pixel_x     = COORD_W'(px);
        out_d.pixel_y     = COORD_W'(py);
        out_d.pixel_color = color_q;
        out_d.last_pixel  = is_last;
        if (is_last) begin
          busy_d = 1'b0;
        end else begin
          p_d = p_q + 1'b1;
          // minor axis steps once the error passes the major length
          if (err_sum > $signed({3'b000, dmaj_q})) begin
            minor_d = up_q ? minor_q + 1'b1 : minor_q - 1'b1;
            err_d   = err_sum - $signed({2'b00, dmaj_q, 1'b0});
          end else begin
            err_d = err_sum;
          end
        end
      end
    end else if (seg_valid_i) begin
      seg_pop_o = 1'b1;
      busy_d    = 1'b1;
      steep_d   = seg_i.steep;
      up_d      = seg_i.minor_up;
      p_d       = seg_i.major_start[C-1:0];
      pend_d    = seg_i.major_end[C-1:0];
      minor_d   = seg_i.minor_start[C-1:0];
      dmaj_d    = seg_i.dmaj[C-1:0];
      dmin2_d   = seg_i.dmin2[C:0];
      err_d     = '0;
      color_d   = seg_i.color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steep_q <= steep_d;
    up_q    <= up_d;
    p_q     <= p_d;
    pend_q  <= pend_d;
    minor_q <= minor_d;
    dmaj_q  <= dmaj_d;
    dmin2_q <= dmin2_d;
    err_q   <= err_d;
    color_q <= color_d;
    out_q   <= out_d;
  end

endmodule

`default_nettype wire

### hdl/bresenham_line_rasterizer.sv
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+----------------------------
// command   | in        | push / full             | cmd_i   (blr_pkg::line_cmd_t)
// pixel     | out       | empty / pop             | pixel_o (blr_pkg::pixel_t)
//
// a line occupies the stepping engine for a load step that takes in the
// classified command, then one pixel per cycle while pop keeps the output free.
// commands are classified on entry and wait in a two-entry queue, so full
// rises once two classified lines wait behind the stepping engine.
// reset empties the queue, idles the engine and clears the output valid; pop held low
// stalls the engine without losing its place.
`default_nettype none

module bresenham_line_rasterizer #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  blr_pkg::line_cmd_t cmd_i,
  output logic               empty,
  input  logic               pop,
  output blr_pkg::pixel_t    pixel_o
);
  import blr_pkg::*;

  seg_t seg_in;
  seg_t seg_out;
  logic seg_valid;
  logic seg_pop;

  blr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .cmd_i (cmd_i),
    .seg_o (seg_in)
  );

  blr_cmd_fifo u_cmdq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (seg_in),
    .full_o    (full),
    .rd_en_i   (seg_pop),
    .rd_data_o (seg_out),
    .valid_o   (seg_valid)
  );

  blr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_valid_i (seg_valid),
    .seg_i       (seg_out),
    .seg_pop_o   (seg_pop),
    .empty       (empty),
    .pop         (pop),
    .pixel_o     (pixel_o)
  );

endmodule

`default_nettype wire

### hdl/blr_checker.sv
`default_nettype none

module blr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input blr_pkg::line_cmd_t cmd_i,
  input logic               empty,
  input logic               pop,
  input blr_pkg::pixel_t    pixel_o
);
  import blr_pkg::*;

  logic mid_line_pop;
  assign mid_line_pop = pop & ~empty & ~pixel_o.last_pixel;

  // a stalled request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(pixel_o))
    else $error("pixel request changed while stalled");

  // within a line the next pixel follows at once with the same color
  a_line_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_line_pop |=> !empty && pixel_o.pixel_color == $past(pixel_o.pixel_color))
    else $error("line broken between pixels");

  // neighboring pixels differ by at most one in each coordinate
  a_step_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_line_pop |=> (pixel_o.pixel_x == $past(pixel_o.pixel_x) ||
                      pixel_o.pixel_x == $past(pixel_o.pixel_x) + 1 ||
                      pixel_o.pixel_x == $past(pixel_o.pixel_x) - 1))
    else $error("column jumped by more than one");

  a_step_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_line_pop |=> (pixel_o.pixel_y == $past(pixel_o.pixel_y) ||
                      pixel_o.pixel_y == $past(pixel_o.pixel_y) + 1 ||
                      pixel_o.pixel_y == $past(pixel_o.pixel_y) - 1))
    else $error("row jumped by more than one");

  // the pixel never stands still along a line
  a_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_line_pop |=> (pixel_o.pixel_x != $past(pixel_o.pixel_x) ||
                      pixel_o.pixel_y != $past(pixel_o.pixel_y)))
    else $error("pixel repeated within a line");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (.*);

`default_nettype wire
